/* rtl/core/bpst_pkg.sv */
// Shared constants, types and helper functions of the bit-packed sum tree.
`timescale 1ns / 1ps
package bpst_pkg;

  localparam int TreeDepth = 16;
  localparam int HeapAw    = TreeDepth - 4;
  localparam int HeapWords = 1 << HeapAw;
  localparam int OffW      = TreeDepth + 4;
  localparam int IdW       = 17;
  localparam int DepthW    = 5;
  localparam int ValW      = 17;
  localparam int CntW      = 5;
  localparam logic [63:0] HeapWord0 = 64'(1) << TreeDepth;

  typedef enum logic [2:0] {
    ModeReset    = 3'd0,
    ModeWrite    = 3'd1,
    ModeReduce   = 3'd2,
    ModeReadNode = 3'd3,
    ModeReadWord = 3'd4
  } mode_e;

  typedef struct packed {
    logic [HeapAw-1:0] lo;
    logic [HeapAw-1:0] hi;
    logic [5:0]        sh;
    logic [6:0]        nlo;
    logic [CntW-1:0]   nhi;
  } field_map_t;

  function automatic logic [63:0] low_ones(input logic [6:0] n);
    logic [63:0] r;
    if (n >= 7'd64) r = '1;
    else r = (64'(1) << n) - 64'(1);
    return r;
  endfunction

  function automatic logic [CntW-1:0] node_width(input logic [DepthW-1:0] d);
    return CntW'(TreeDepth + 1) - d;
  endfunction

  function automatic logic [OffW-1:0] node_offset(input logic [IdW-1:0] id,
                                                  input logic [DepthW-1:0] d);
    logic [OffW-1:0] base;
    base = OffW'(2) << d;
    return base + OffW'(id) * OffW'(node_width(d));
  endfunction

  // Leaf-area word after a reset to depth d: bit set at every stride 2^(D-d)
  // in the upper half of the leaf area, everything else clear.
  function automatic logic [63:0] fill_word(input logic [HeapAw-1:0] w,
                                            input logic [DepthW-1:0] d);
    logic [63:0]       r;
    logic [HeapAw+5:0] p;
    logic [HeapAw+5:0] m;
    m = (HeapAw+6)'((64'(1) << (DepthW'(TreeDepth) - d)) - 64'(1));
    for (int b = 0; b < 64; b++) begin
      p = {w, 6'(b)};
      r[b] = (w[HeapAw-1:HeapAw-2] == 2'b11) && ((p & m) == '0);
    end
    return r;
  endfunction

endpackage

/* rtl/core/bpst_heap.sv */
// Heap word memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module bpst_heap
  import bpst_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [HeapAw-1:0] waddr_i,
  input  logic [63:0]       wdata_i,
  input  logic              re_i,
  input  logic [HeapAw-1:0] raddr_i,
  output logic [63:0]       rdata_o
);

  logic [63:0] mem [HeapWords];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bpst_field.sv */
// Maps a packed field (bit offset, bit count) onto its one or two heap words.
`timescale 1ns / 1ps
module bpst_field
  import bpst_pkg::*;
(
  input  logic [OffW-1:0] off_i,
  input  logic [CntW-1:0] cnt_i,
  output field_map_t      map_o
);

  logic [6:0] room;
  logic [6:0] nlo;

  always_comb begin
    map_o.lo  = off_i[HeapAw+5:6];
    map_o.hi  = (map_o.lo == HeapAw'(HeapWords - 1)) ? map_o.lo : map_o.lo + HeapAw'(1);
    map_o.sh  = off_i[5:0];
    room      = 7'd64 - 7'(off_i[5:0]);
    nlo       = (room < 7'(cnt_i)) ? room : 7'(cnt_i);
    map_o.nlo = nlo;
    map_o.nhi = cnt_i - CntW'(nlo);
  end

endmodule

/* rtl/core/bit_packed_sum_tree_top.sv */
// Top level of the bit-packed sum tree: request sequencer around the heap memory.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request beat: mode, node id,
//   node depth, leaf bit and word index. Output channel (out_valid_o/out_ready_i)
//   returns one result beat per request: node value, heap word and bad flag.
//   All state lives in one 4096 x 64 heap memory, one read and one write per
//   cycle, read data registered; each request runs as a sequence of reads and
//   writes on that single port pair, one request at a time.
// Steps from accept to result ready:
//   rejected request or bad mode none, read word one read, write leaf read then write,
//   read node one or two word reads, reset to depth a write of each leaf-area word,
//   reduce per inner node over 2^16-1 nodes (field reads of both children and
//   read-modify-writes of the parent, each possibly split across two words).
// Flow: the next request is accepted once the sequencer is back in idle;
//   a finished result sits in the output register, so a stalled receiver does
//   not stop the next request from running. The sequencer only waits when it
//   has another result and the output register is still full.
// Reset: after rst_ni all 4096 memory words are swept, writing 2^16 to word 0
//   and zero elsewhere; in_ready_o stays low during that pass.
module bit_packed_sum_tree_top
  import bpst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        mode_i,
  input  logic [IdW-1:0]    node_id_i,
  input  logic [DepthW-1:0] node_depth_i,
  input  logic              leaf_bit_i,
  input  logic [HeapAw-1:0] word_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValW-1:0]   node_value_o,
  output logic [63:0]       word_data_o,
  output logic              bad_request_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FILL, S_LEAF_RD, S_LEAF_WR, S_WORD_RD, S_WORD_D,
    S_RED_NODE, S_FRD, S_FRD_LO, S_FRD_HI, S_FWR, S_FWR_LO, S_FWR_HI_RD,
    S_FWR_HI, S_DONE
  } state_e;

  state_e            state_q;
  logic [HeapAw-1:0] cnt_q;
  logic [OffW-1:0]   off_q;
  logic [CntW-1:0]   fcnt_q;
  logic [DepthW-1:0] depth_q;
  logic [IdW-1:0]    id_q;
  logic              bit_q;
  logic              red_q;
  logic              phase_q;
  logic [ValW-1:0]   acc_q;
  logic [ValW-1:0]   a_q;
  logic [ValW-1:0]   res_value_q;
  logic [63:0]       res_data_q;
  logic              res_bad_q;
  logic              out_valid_q;
  logic [ValW-1:0]   node_value_q;
  logic [63:0]       word_data_q;
  logic              bad_request_q;

  // heap port
  logic              ram_we;
  logic [HeapAw-1:0] ram_waddr;
  logic [63:0]       ram_wdata;
  logic              ram_re;
  logic [HeapAw-1:0] ram_raddr;
  logic [63:0]       ram_rdata;

  field_map_t        fmap;

  bpst_heap u_heap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bpst_field u_field (
    .off_i(off_q),
    .cnt_i(fcnt_q),
    .map_o(fmap)
  );

  // Request checks on the incoming beat.
  logic depth_bad;
  logic id_bad;
  assign depth_bad = node_depth_i > DepthW'(TreeDepth);
  assign id_bad    = ({1'b0, node_id_i} < ((IdW+1)'(1) << node_depth_i)) ||
                     ({1'b0, node_id_i} >= ((IdW+1)'(2) << node_depth_i));

  // Leaf bit address of the held node.
  logic [OffW-1:0]   leaf_off;
  logic [HeapAw-1:0] leaf_word;
  logic [5:0]        leaf_b;
  assign leaf_off  = (OffW'(1) << (TreeDepth + 1)) +
                     (OffW'(id_q) << (DepthW'(TreeDepth) - depth_q));
  assign leaf_word = leaf_off[HeapAw+5:6];
  assign leaf_b    = leaf_off[5:0];

  // Field extraction and merge.
  logic [63:0]     lo_full;
  logic [ValW-1:0] lo_part;
  logic [ValW-1:0] hi_part;
  logic [ValW-1:0] fin_v;
  logic [63:0]     m_lo;
  logic [63:0]     m_hi;
  assign lo_full = (ram_rdata >> fmap.sh) & low_ones(fmap.nlo);
  assign lo_part = lo_full[ValW-1:0];
  assign hi_part = ValW'((ram_rdata & low_ones(7'(fmap.nhi))) << fmap.nlo);
  assign fin_v   = (state_q == S_FRD_HI) ? (acc_q | hi_part) : lo_part;
  assign m_lo    = low_ones(fmap.nlo) << fmap.sh;
  assign m_hi    = low_ones(7'(fmap.nhi));

  // Reduce addressing for the held parent node.
  logic [OffW-1:0] off_ca;
  logic [OffW-1:0] off_cb;
  logic [OffW-1:0] off_par;
  logic            last_id;
  assign off_ca  = node_offset({id_q[IdW-2:0], 1'b0}, depth_q + DepthW'(1));
  assign off_cb  = node_offset({id_q[IdW-2:0], 1'b1}, depth_q + DepthW'(1));
  assign off_par = node_offset(id_q, depth_q);
  assign last_id = ({1'b0, id_q} + (IdW+1)'(1)) == ((IdW+1)'(2) << depth_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = fmap.lo;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (cnt_q == '0) ? HeapWord0 : '0;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_word(cnt_q, depth_q);
      end
      S_LEAF_RD: begin
        ram_re    = 1'b1;
        ram_raddr = leaf_word;
      end
      S_LEAF_WR: begin
        ram_we    = 1'b1;
        ram_waddr = leaf_word;
        ram_wdata = (ram_rdata & ~(64'(1) << leaf_b)) | (64'(bit_q) << leaf_b);
      end
      S_WORD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
      end
      S_FRD, S_FWR: begin
        ram_re = 1'b1;
      end
      S_FRD_LO: begin
        ram_re    = fmap.nhi != '0;
        ram_raddr = fmap.hi;
      end
      S_FWR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = fmap.lo;
        ram_wdata = (ram_rdata & ~m_lo) | ((64'(acc_q) << fmap.sh) & m_lo);
      end
      S_FWR_HI_RD: begin
        ram_re    = 1'b1;
        ram_raddr = fmap.hi;
      end
      S_FWR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = fmap.hi;
        ram_wdata = (ram_rdata & ~m_hi) | ((64'(acc_q) >> fmap.nlo) & m_hi);
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      red_q         <= 1'b0;
      phase_q       <= 1'b0;
      res_bad_q     <= 1'b0;
      res_value_q   <= '0;
      res_data_q    <= '0;
      off_q         <= '0;
      fcnt_q        <= '0;
      depth_q       <= '0;
      id_q          <= '0;
      bit_q         <= 1'b0;
      acc_q         <= '0;
      a_q           <= '0;
      node_value_q  <= '0;
      word_data_q   <= '0;
      bad_request_q <= 1'b0;
    end else begin
      // drop the result once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + HeapAw'(1);
          if (cnt_q == HeapAw'(HeapWords - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            id_q        <= node_id_i;
            depth_q     <= node_depth_i;
            bit_q       <= leaf_bit_i;
            res_value_q <= '0;
            res_data_q  <= '0;
            res_bad_q   <= 1'b0;
            unique case (mode_i)
              ModeReset: begin
                if (depth_bad) begin
                  res_bad_q <= 1'b1;
                  state_q   <= S_DONE;
                end else begin
                  cnt_q   <= HeapAw'(HeapWords / 2);
                  state_q <= S_FILL;
                end
              end
              ModeWrite: begin
                if (depth_bad || id_bad) begin
                  res_bad_q <= 1'b1;
                  state_q   <= S_DONE;
                end else begin
                  state_q <= S_LEAF_RD;
                end
              end
              ModeReduce: begin
                red_q   <= 1'b1;
                depth_q <= DepthW'(TreeDepth - 1);
                id_q    <= IdW'(1) << (TreeDepth - 1);
                state_q <= S_RED_NODE;
              end
              ModeReadNode: begin
                if (depth_bad || id_bad) begin
                  res_bad_q <= 1'b1;
                  state_q   <= S_DONE;
                end else begin
                  red_q   <= 1'b0;
                  off_q   <= node_offset(node_id_i, node_depth_i);
                  fcnt_q  <= node_width(node_depth_i);
                  state_q <= S_FRD;
                end
              end
              ModeReadWord: begin
                cnt_q   <= word_index_i;
                state_q <= S_WORD_RD;
              end
              default: begin
                res_bad_q <= 1'b1;
                state_q   <= S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          cnt_q <= cnt_q + HeapAw'(1);
          if (cnt_q == HeapAw'(HeapWords - 1)) state_q <= S_DONE;
        end
        S_LEAF_RD: state_q <= S_LEAF_WR;
        S_LEAF_WR: state_q <= S_DONE;
        S_WORD_RD: state_q <= S_WORD_D;
        S_WORD_D: begin
          res_data_q <= ram_rdata;
          state_q    <= S_DONE;
        end
        S_RED_NODE: begin
          phase_q <= 1'b0;
          off_q   <= off_ca;
          fcnt_q  <= node_width(depth_q + DepthW'(1));
          state_q <= S_FRD;
        end
        S_FRD: state_q <= S_FRD_LO;
        S_FRD_LO, S_FRD_HI: begin
          if (state_q == S_FRD_LO && fmap.nhi != '0) begin
            acc_q   <= lo_part;
            state_q <= S_FRD_HI;
          end else if (!red_q) begin
            res_value_q <= fin_v;
            state_q     <= S_DONE;
          end else if (!phase_q) begin
            a_q     <= fin_v;
            phase_q <= 1'b1;
            off_q   <= off_cb;
            state_q <= S_FRD;
          end else begin
            acc_q   <= a_q + fin_v;
            off_q   <= off_par;
            fcnt_q  <= node_width(depth_q);
            state_q <= S_FWR;
          end
        end
        S_FWR: state_q <= S_FWR_LO;
        S_FWR_LO, S_FWR_HI: begin
          if (state_q == S_FWR_LO && fmap.nhi != '0) begin
            state_q <= S_FWR_HI_RD;
          end else if (!last_id) begin
            id_q    <= id_q + IdW'(1);
            state_q <= S_RED_NODE;
          end else if (depth_q == '0) begin
            state_q <= S_DONE;
          end else begin
            depth_q <= depth_q - DepthW'(1);
            id_q    <= IdW'(1) << (depth_q - DepthW'(1));
            state_q <= S_RED_NODE;
          end
        end
        S_FWR_HI_RD: state_q <= S_FWR_HI;
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            node_value_q  <= res_value_q;
            word_data_q   <= res_data_q;
            bad_request_q <= res_bad_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign node_value_o  = node_value_q;
  assign word_data_o   = word_data_q;
  assign bad_request_o = bad_request_q;

`ifndef SYNTHESIS
  a_one_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (node_value_o == '0 || word_data_o == '0))
    else $error("node value and word data both nonzero");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_request_o) |-> (node_value_o == '0 && word_data_o == '0))
    else $error("rejected beat carries data");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("heap read and write in the same cycle");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("request accepted during memory clear");
`endif

endmodule

/* bench/tb_bit_packed_sum_tree_top.sv */
// Self-checking testbench for the bit-packed sum tree top level.
`timescale 1ns / 1ps
module tb_bit_packed_sum_tree_top;
  import bpst_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. One reduce
  // walks all 2^16-1 inner nodes with no beat on either channel, so the limit
  // sits well above the length of one reduce.
  localparam int unsigned HangLimit = 4_000_000;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [63:0]     data;
    logic            bad;
  } tree_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        mode;
  logic [IdW-1:0]    node_id;
  logic [DepthW-1:0] node_depth;
  logic              leaf_bit;
  logic [HeapAw-1:0] word_index;
  logic              out_valid;
  logic              out_ready;
  logic [ValW-1:0]   node_value;
  logic [63:0]       word_data;
  logic              bad_request;

  // Shadow copy of the heap memory and the results still owed by the block.
  logic [63:0]  shadow_heap [HeapWords];
  tree_result_t owed_results[$];

  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold_cycles;
  int          mismatches;
  int unsigned quiet_cycles;

  bit_packed_sum_tree_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .node_id_i     (node_id),
    .node_depth_i  (node_depth),
    .leaf_bit_i    (leaf_bit),
    .word_index_i  (word_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .node_value_o  (node_value),
    .word_data_o   (word_data),
    .bad_request_o (bad_request)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Heap predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] ones(input int unsigned n);
    if (n >= 64) return '1;
    return (64'(1) << n) - 64'(1);
  endfunction

  function automatic int unsigned field_base(input int unsigned id, input int unsigned d);
    return (2 << d) + id * (TreeDepth + 1 - d);
  endfunction

  // A field may run past the end of its word; the tail lands at bit 0 of the
  // next word, and that next index sticks at the last word.
  function automatic logic [63:0] get_bits(input int unsigned off, input int unsigned cnt);
    int unsigned lo, hi, sh, nlo, nhi;
    logic [63:0] v;
    lo  = (off >> 6) % HeapWords;
    hi  = (lo + 1 < HeapWords) ? lo + 1 : HeapWords - 1;
    sh  = off & 63;
    nlo = (64 - sh < cnt) ? 64 - sh : cnt;
    nhi = cnt - nlo;
    v   = (shadow_heap[lo] >> sh) & ones(nlo);
    if (nhi > 0) v |= (shadow_heap[hi] & ones(nhi)) << nlo;
    return v;
  endfunction

  function automatic void put_bits(input int unsigned off, input int unsigned cnt,
                                   input logic [63:0] val);
    int unsigned lo, hi, sh, nlo, nhi;
    logic [63:0] m;
    lo  = (off >> 6) % HeapWords;
    hi  = (lo + 1 < HeapWords) ? lo + 1 : HeapWords - 1;
    sh  = off & 63;
    nlo = (64 - sh < cnt) ? 64 - sh : cnt;
    nhi = cnt - nlo;
    m   = ones(nlo) << sh;
    shadow_heap[lo] = (shadow_heap[lo] & ~m) | ((val << sh) & m);
    if (nhi > 0) begin
      m = ones(nhi);
      shadow_heap[hi] = (shadow_heap[hi] & ~m) | ((val >> nlo) & m);
    end
  endfunction

  function automatic void put_leaf(input int unsigned id, input int unsigned d,
                                   input logic bit_val);
    int unsigned off;
    off = (2 << TreeDepth) + (id << (TreeDepth - d));
    shadow_heap[(off >> 6) % HeapWords][off & 63] = bit_val;
  endfunction

  function automatic bit node_in_level(input int unsigned id, input int unsigned d);
    return d <= TreeDepth && id >= (1 << d) && id < (2 << d);
  endfunction

  function automatic tree_result_t tree_predict(input logic [2:0] m, input int unsigned id,
                                                input int unsigned d, input logic b,
                                                input int unsigned widx);
    tree_result_t r;
    int unsigned  lhs, rhs;
    r = '0;
    case (m)
      ModeReset: begin
        if (d > TreeDepth) r.bad = 1'b1;
        else begin
          for (int w = 1 << (TreeDepth - 5); w < HeapWords; w++) shadow_heap[w] = '0;
          for (int unsigned n = 1 << d; n < (2 << d); n++) put_leaf(n, d, 1'b1);
        end
      end
      ModeWrite: begin
        if (!node_in_level(id, d)) r.bad = 1'b1;
        else put_leaf(id, d, b);
      end
      ModeReduce: begin
        // Sum children into parents bottom-up, one level at a time.
        for (int lv = TreeDepth - 1; lv >= 0; lv--) begin
          for (int unsigned n = 1 << lv; n < (2 << lv); n++) begin
            lhs = get_bits(field_base(2 * n, lv + 1), TreeDepth - lv);
            rhs = get_bits(field_base(2 * n + 1, lv + 1), TreeDepth - lv);
            put_bits(field_base(n, lv), TreeDepth + 1 - lv, 64'(lhs + rhs));
          end
        end
      end
      ModeReadNode: begin
        if (!node_in_level(id, d)) r.bad = 1'b1;
        else r.value = ValW'(get_bits(field_base(id, d), TreeDepth + 1 - d));
      end
      ModeReadWord: r.data = shadow_heap[widx % HeapWords];
      default: r.bad = 1'b1;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offer one beat, hold it until accepted, then predict it
  // ---------------------------------------------------------------------------

  task automatic send_req(input logic [2:0] m, input logic [IdW-1:0] id,
                          input logic [DepthW-1:0] d, input logic b,
                          input logic [HeapAw-1:0] widx);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    node_id    <= id;
    node_depth <= d;
    leaf_bit   <= b;
    word_index <= widx;
    do @(posedge clk); while (!in_ready);
    owed_results.push_back(tree_predict(m, id, d, b, widx));
  endtask

  // Hold the sender until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    tree_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $error("result beat with nothing outstanding");
        mismatches++;
      end else begin
        exp_res = owed_results.pop_front();
        if (node_value !== exp_res.value) begin
          $error("node_value expected %0h got %0h", exp_res.value, node_value);
          mismatches++;
        end
        if (word_data !== exp_res.data) begin
          $error("word_data expected %0h got %0h", exp_res.data, word_data);
          mismatches++;
        end
        if (bad_request !== exp_res.bad) begin
          $error("bad_request expected %0b got %0b", exp_res.bad, bad_request);
          mismatches++;
        end
      end
    end
  end

  // Receiver: a long hold-off takes priority over the random stall pattern.
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      out_ready      <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HangLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Unused modes, depth beyond the tree, ids outside their level.
  task automatic test_bad_requests();
    send_req(3'd5, '0, '0, 1'b0, '0);
    send_req(3'd6, '1, '1, 1'b1, '1);
    send_req(3'd7, 17'd5, 5'd2, 1'b0, 12'd7);
    send_req(ModeReset, '0, 5'd17, 1'b0, '0);
    send_req(ModeWrite, 17'd1, 5'd31, 1'b1, '0);
    send_req(ModeReadNode, 17'd2, 5'd17, 1'b0, '0);
    send_req(ModeWrite, 17'd0, 5'd0, 1'b1, '0);
    send_req(ModeReadNode, 17'd4, 5'd1, 1'b0, '0);
  endtask

  // Full and empty subdivision, leaf writes at the edges, word reads at the ends.
  task automatic test_reset_and_leaves();
    send_req(ModeReset, '0, 5'd16, 1'b0, '0);
    send_req(ModeReadWord, '0, '0, 1'b0, 12'd4095);
    send_req(ModeReadWord, '0, '0, 1'b0, 12'd2048);
    send_req(ModeReadWord, '0, '0, 1'b0, 12'd0);
    send_req(ModeReadNode, 17'd131071, 5'd16, 1'b0, '0);
    send_req(ModeReset, '0, 5'd0, 1'b0, '0);
    send_req(ModeReadWord, '0, '0, 1'b0, 12'd3072);
    send_req(ModeWrite, 17'd131071, 5'd16, 1'b1, '0);
    send_req(ModeWrite, 17'd65536, 5'd16, 1'b0, '0);
    send_req(ModeWrite, 17'd1, 5'd0, 1'b1, '0);
    send_req(ModeReadNode, 17'd65536, 5'd16, 1'b0, '0);
    send_req(ModeReadWord, '0, '0, 1'b0, 12'd4095);
  endtask

  // One full bottom-up reduction, then read back the root, node 3 and heap word 0.
  task automatic test_reduce();
    send_req(ModeReduce, '0, '0, 1'b0, '0);
    send_req(ModeReadNode, 17'd1, 5'd0, 1'b0, '0);
    send_req(ModeReadNode, 17'd3, 5'd1, 1'b0, '0);
    send_req(ModeReadWord, '0, '0, 1'b0, 12'd0);
  endtask

  // Mostly legal requests with random content, plus some noise. Reduce stays
  // out of the random mix since each one walks the whole tree.
  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    int          pick;
    int unsigned d;
    logic [2:0]  m;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      d    = $urandom_range(TreeDepth);
      if (pick < 3) begin
        d = ($urandom_range(3) == 0) ? $urandom_range(TreeDepth) : $urandom_range(8);
        send_req(ModeReset, 17'($urandom), 5'(d), 1'($urandom), 12'($urandom));
      end else if (pick < 43) begin
        send_req(ModeWrite, 17'((1 << d) | ($urandom & ((1 << d) - 1))), 5'(d),
                 1'($urandom), 12'($urandom));
      end else if (pick < 73) begin
        send_req(ModeReadNode, 17'((1 << d) | ($urandom & ((1 << d) - 1))), 5'(d),
                 1'($urandom), 12'($urandom));
      end else if (pick < 93) begin
        send_req(ModeReadWord, 17'($urandom), 5'($urandom), 1'($urandom), 12'($urandom));
      end else begin
        // Noise: raw fields; reset only with an out-of-range depth, never reduce.
        m = 3'($urandom);
        if (m == ModeReduce) m = 3'd5;
        if (m == ModeReset) send_req(m, 17'($urandom), 5'($urandom_range(31, 17)),
                                     1'($urandom), 12'($urandom));
        else send_req(m, 17'($urandom), 5'($urandom), 1'($urandom), 12'($urandom));
      end
    end
  endtask

  // Block the receiver for a long stretch while the sender keeps offering, so
  // the result register fills and the input stalls; then drain completely.
  task automatic test_backpressure();
    tx_idle_pct    = 0;
    rx_hold_cycles = 400;
    for (int i = 0; i < 20; i++)
      send_req(ModeReadWord, '0, '0, 1'b0, 12'($urandom));
    wait_drained();
    send_req(ModeReadNode, 17'd1, 5'd0, 1'b0, '0);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    mode           = '0;
    node_id        = '0;
    node_depth     = '0;
    leaf_bit       = 1'b0;
    word_index     = '0;
    out_ready      = 1'b0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_cycles = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    for (int w = 0; w < HeapWords; w++) shadow_heap[w] = '0;
    shadow_heap[0] = 64'(1) << TreeDepth;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    test_bad_requests();
    test_reset_and_leaves();
    test_reduce();
    test_random(400, 6, 87);
    test_random(400, 87, 6);
    test_backpressure();
    test_random(400, 0, 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
